### hw/rtl/pae_pkg.sv
// pae_pkg: shared types, constants and helper functions of particle_advect_step.
// No dependencies; used by pae_muldiv and particle_advect_step.
package pae_pkg;

    localparam int INDEX_BITS = 16;
    localparam int DIV_STEPS  = 32;   // one quotient bit per divider stage
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP      = 3'd0,
        CFG_BROWNIAN_SCALE = 3'd1,
        CFG_X_LOWER        = 3'd2,
        CFG_X_UPPER        = 3'd3,
        CFG_Y_LOWER        = 3'd4,
        CFG_Y_UPPER        = 3'd5,
        CFG_REENTRY_Y      = 3'd6
    } t_cfg_idx;

    localparam logic [23:0] RST_TIME_STEP      = 24'd16777;
    localparam logic [23:0] RST_BROWNIAN_SCALE = 24'd237266;
    localparam logic [31:0] RST_X_LOWER        = 32'd1677722;
    localparam logic [31:0] RST_X_UPPER        = 32'd149317222;
    localparam logic [31:0] RST_Y_LOWER        = 32'd1677722;
    localparam logic [31:0] RST_Y_UPPER        = 32'd52009370;
    localparam logic [31:0] RST_REENTRY_Y      = 32'd26843546;

    // sideband that rides along the divider pipeline
    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic signed [31:0]    px;
        logic signed [31:0]    py;
        logic signed [31:0]    dx;
        logic signed [31:0]    dy;
        logic                  hit;
        logic                  en_x;   // projection keeps x motion
        logic                  neg_x;
        logic                  en_y;
        logic                  neg_y;
    } t_side;

    typedef struct packed {
        logic [64:0] r;
        logic [32:0] q;
    } t_dstep;

    // one step of the shift-and-subtract a*b/n loop
    function automatic t_dstep div_step(input logic [64:0] r, input logic [32:0] q,
                                        input logic abit, input logic [63:0] b,
                                        input logic [63:0] n);
        logic [64:0] r1;
        logic [32:0] q1;
        t_dstep      o;
        r1 = {r[63:0], 1'b0};
        q1 = {q[31:0], 1'b0};
        if (r1 >= {1'b0, n}) begin
            r1 = r1 - {1'b0, n};
            q1 = q1 + 33'd1;
        end
        if (abit) begin
            r1 = r1 + {1'b0, b};
            if (r1 >= {1'b0, n}) begin
                r1 = r1 - {1'b0, n};
                q1 = q1 + 33'd1;
            end
        end
        o.r = r1;
        o.q = q1;
        return o;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] o;
        if (v > 36'sd2147483647)       o = 32'sh7FFF_FFFF;
        else if (v < -36'sd2147483648) o = 32'sh8000_0000;
        else                           o = v[31:0];
        return o;
    endfunction

endpackage

### hw/rtl/pae_muldiv.sv
// pae_muldiv: pipelined floor(a*b/n), one quotient bit per stage, for x and y.
// Depends on pae_pkg.
module pae_muldiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_vld,
    input  logic [31:0]          i_a_x,
    input  logic [63:0]          i_b_x,
    input  logic [31:0]          i_a_y,
    input  logic [63:0]          i_b_y,
    input  logic [63:0]          i_n,
    input  pae_pkg::t_side       i_side,
    output logic                 o_vld,
    output logic [31:0]          o_q_x,
    output logic [31:0]          o_q_y,
    output pae_pkg::t_side       o_side
);

    localparam int N = pae_pkg::DIV_STEPS;

    logic           r_vld [N+1];
    logic [31:0]    r_a_x [N+1];
    logic [31:0]    r_a_y [N+1];
    logic [63:0]    r_b_x [N+1];
    logic [63:0]    r_b_y [N+1];
    logic [63:0]    r_n   [N+1];
    logic [64:0]    r_r_x [N+1];
    logic [64:0]    r_r_y [N+1];
    logic [32:0]    r_q_x [N+1];
    logic [32:0]    r_q_y [N+1];
    pae_pkg::t_side r_side[N+1];

    assign r_vld[0]  = i_vld;
    assign r_a_x[0]  = i_a_x;
    assign r_a_y[0]  = i_a_y;
    assign r_b_x[0]  = i_b_x;
    assign r_b_y[0]  = i_b_y;
    assign r_n[0]    = i_n;
    assign r_r_x[0]  = '0;
    assign r_r_y[0]  = '0;
    assign r_q_x[0]  = '0;
    assign r_q_y[0]  = '0;
    assign r_side[0] = i_side;

    for (genvar s = 0; s < N; s++) begin : g_step
        pae_pkg::t_dstep n_x, n_y;
        always_comb begin
            n_x = pae_pkg::div_step(r_r_x[s], r_q_x[s], r_a_x[s][31], r_b_x[s], r_n[s]);
            n_y = pae_pkg::div_step(r_r_y[s], r_q_y[s], r_a_y[s][31], r_b_y[s], r_n[s]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_adv) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_a_x[s+1]  <= {r_a_x[s][30:0], 1'b0};
                r_a_y[s+1]  <= {r_a_y[s][30:0], 1'b0};
                r_b_x[s+1]  <= r_b_x[s];
                r_b_y[s+1]  <= r_b_y[s];
                r_n[s+1]    <= r_n[s];
                r_r_x[s+1]  <= n_x.r;
                r_r_y[s+1]  <= n_y.r;
                r_q_x[s+1]  <= n_x.q;
                r_q_y[s+1]  <= n_y.q;
                r_side[s+1] <= r_side[s];
            end
        end
    end

    assign o_vld  = r_vld[N];
    assign o_q_x  = r_q_x[N][31:0];
    assign o_q_y  = r_q_y[N][31:0];
    assign o_side = r_side[N];

endmodule

### hw/rtl/particle_advect_step.sv
// particle_advect_step: top level of the one-particle Brownian advection step.
// Depends on pae_pkg and pae_muldiv.
//
// Takes one particle per cycle while the pipeline advances and returns its
// updated position (3 front, 32 divider and 2 back stages). The depth
// is set by the near-wall projection g^2*|d|/|g|^2, done as a bit-serial
// shift-and-subtract divider with one stage per quotient bit. The whole
// pipeline advances whenever the output register is empty or its transfer
// completes, so o_s_axis_tready follows i_m_axis_tready with no bubbles.
// Configuration writes act at once; write them only while no particle is in
// flight.
module particle_advect_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic [pae_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    // particle in
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // lsb up: particle_index, pos_x, pos_y, vel_x, vel_y, wall_distance,
    //         grad_x, grad_y, noise_x, noise_y
    input  logic [271:0]                  i_s_axis_tdata,
    // result out
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // lsb up: out_index, new_x, new_y
    output logic [79:0]                   o_m_axis_tdata,
    // lsb up: wall_hit, wrapped
    output logic [1:0]                    o_m_axis_tuser
);

    localparam int IW = pae_pkg::INDEX_BITS;

    // ---------------- configuration registers ----------------
    logic [23:0]        r_dt, r_sc;
    logic signed [31:0] r_xl, r_xu, r_yl, r_yu, r_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= pae_pkg::RST_TIME_STEP;
            r_sc <= pae_pkg::RST_BROWNIAN_SCALE;
            r_xl <= pae_pkg::RST_X_LOWER;
            r_xu <= pae_pkg::RST_X_UPPER;
            r_yl <= pae_pkg::RST_Y_LOWER;
            r_yu <= pae_pkg::RST_Y_UPPER;
            r_ry <= pae_pkg::RST_REENTRY_Y;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pae_pkg::CFG_TIME_STEP:      r_dt <= i_cfg_data[23:0];
                pae_pkg::CFG_BROWNIAN_SCALE: r_sc <= i_cfg_data[23:0];
                pae_pkg::CFG_X_LOWER:        r_xl <= i_cfg_data;
                pae_pkg::CFG_X_UPPER:        r_xu <= i_cfg_data;
                pae_pkg::CFG_Y_LOWER:        r_yl <= i_cfg_data;
                pae_pkg::CFG_Y_UPPER:        r_yu <= i_cfg_data;
                pae_pkg::CFG_REENTRY_Y:      r_ry <= i_cfg_data;
                default: ;                   // unused index: ignored
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic w_adv;
    logic r_v1, r_v2, r_v3, r_v5, r_v6, w_v4;
    assign w_adv           = !r_v6 || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // ---------------- stage 1: capture, |g| ----------------
    logic [IW-1:0]      r1_idx;
    logic signed [31:0] r1_px, r1_py, r1_vx, r1_vy, r1_dist;
    logic signed [15:0] r1_nx, r1_ny;
    logic [31:0]        r1_agx, r1_agy;
    logic signed [31:0] w_gx, w_gy;

    assign w_gx = i_s_axis_tdata[207:176];
    assign w_gy = i_s_axis_tdata[239:208];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_idx  <= i_s_axis_tdata[IW-1:0];
            r1_px   <= i_s_axis_tdata[47:16];
            r1_py   <= i_s_axis_tdata[79:48];
            r1_vx   <= i_s_axis_tdata[111:80];
            r1_vy   <= i_s_axis_tdata[143:112];
            r1_dist <= i_s_axis_tdata[175:144];
            r1_nx   <= i_s_axis_tdata[255:240];
            r1_ny   <= i_s_axis_tdata[271:256];
            r1_agx  <= w_gx[31] ? 32'(-w_gx) : w_gx;
            r1_agy  <= w_gy[31] ? 32'(-w_gy) : w_gy;
        end
    end

    // keep raw gradient signs for the projection test
    logic r1_gx_neg, r1_gy_neg, r2_gx_neg, r2_gy_neg, r3_gx_neg, r3_gy_neg;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_gx_neg <= w_gx[31];
            r1_gy_neg <= w_gy[31];
        end
    end

    // ---------------- stage 2: products ----------------
    logic [IW-1:0]      r2_idx;
    logic signed [31:0] r2_px, r2_py, r2_dist;
    logic signed [56:0] r2_pvx, r2_pvy;     // vel * dt
    logic signed [40:0] r2_pnx, r2_pny;     // scale * noise
    logic [63:0]        r2_gx2, r2_gy2;
    logic [31:0]        r2_agx, r2_agy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_idx    <= r1_idx;
            r2_px     <= r1_px;
            r2_py     <= r1_py;
            r2_dist   <= r1_dist;
            r2_pvx    <= r1_vx * $signed({1'b0, r_dt});
            r2_pvy    <= r1_vy * $signed({1'b0, r_dt});
            r2_pnx    <= $signed({1'b0, r_sc}) * r1_nx;
            r2_pny    <= $signed({1'b0, r_sc}) * r1_ny;
            r2_gx2    <= r1_agx * r1_agx;
            r2_gy2    <= r1_agy * r1_agy;
            r2_agx    <= r1_agx;
            r2_agy    <= r1_agy;
            r2_gx_neg <= r1_gx_neg;
            r2_gy_neg <= r1_gy_neg;
        end
    end

    // ---------------- stage 3: round, sum, saturate; |g|^2 ----------------
    // round to nearest, ties up: add half an lsb then shift arithmetically
    logic signed [57:0] w_tvx, w_tvy;
    logic signed [41:0] w_tnx, w_tny;
    logic signed [35:0] w_sx, w_sy;

    assign w_tvx = ($signed({r2_pvx[56], r2_pvx}) + 58'sd8388608) >>> 24;
    assign w_tvy = ($signed({r2_pvy[56], r2_pvy}) + 58'sd8388608) >>> 24;
    assign w_tnx = ($signed({r2_pnx[40], r2_pnx}) + 42'sd2048) >>> 12;
    assign w_tny = ($signed({r2_pny[40], r2_pny}) + 42'sd2048) >>> 12;
    // both terms fit in 36 signed bits, so the low 36 bits keep the sign
    assign w_sx  = $signed(w_tvx[35:0]) + $signed(w_tnx[35:0]);
    assign w_sy  = $signed(w_tvy[35:0]) + $signed(w_tny[35:0]);

    logic [IW-1:0]      r3_idx;
    logic signed [31:0] r3_px, r3_py, r3_dist, r3_dx, r3_dy;
    logic [63:0]        r3_n, r3_gx2, r3_gy2;
    logic               r3_gx_z, r3_gy_z;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_idx    <= r2_idx;
            r3_px     <= r2_px;
            r3_py     <= r2_py;
            r3_dist   <= r2_dist;
            r3_dx     <= pae_pkg::sat32(w_sx);
            r3_dy     <= pae_pkg::sat32(w_sy);
            r3_n      <= r2_gx2 + r2_gy2;
            r3_gx2    <= r2_gx2;
            r3_gy2    <= r2_gy2;
            r3_gx_z   <= (r2_agx == '0);
            r3_gy_z   <= (r2_agy == '0);
            r3_gx_neg <= r2_gx_neg;
            r3_gy_neg <= r2_gy_neg;
        end
    end

    // ---------------- stage 4: near-wall test, divider setup ----------------
    pae_pkg::t_side w_side_in, w_side_out;
    logic [31:0]    w_adx, w_ady, w_qx, w_qy;

    always_comb begin
        w_side_in.idx   = r3_idx;
        w_side_in.px    = r3_px;
        w_side_in.py    = r3_py;
        w_side_in.dx    = r3_dx;
        w_side_in.dy    = r3_dy;
        // dist <= 2*dx or dist < 2*dy, without saturating the doubled value
        w_side_in.hit   = ($signed({r3_dist[31], r3_dist}) <= $signed({r3_dx, 1'b0}))
                       || ($signed({r3_dist[31], r3_dist}) <  $signed({r3_dy, 1'b0}));
        // motion kept only along the gradient, same sign; zero g gives zero
        w_side_in.en_x  = !r3_gx_z && (r3_dx != '0) && (r3_gx_neg == r3_dx[31]);
        w_side_in.en_y  = !r3_gy_z && (r3_dy != '0) && (r3_gy_neg == r3_dy[31]);
        w_side_in.neg_x = r3_dx[31];
        w_side_in.neg_y = r3_dy[31];
        w_adx = r3_dx[31] ? 32'(-r3_dx) : r3_dx;
        w_ady = r3_dy[31] ? 32'(-r3_dy) : r3_dy;
    end

    pae_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_v3),
        .i_a_x   (w_adx),
        .i_b_x   (r3_gx2),
        .i_a_y   (w_ady),
        .i_b_y   (r3_gy2),
        .i_n     (r3_n),
        .i_side  (w_side_in),
        .o_vld   (w_v4),
        .o_q_x   (w_qx),
        .o_q_y   (w_qy),
        .o_side  (w_side_out)
    );

    // ---------------- stage 5: final displacement, position sum ----------------
    logic signed [31:0] w_fdx, w_fdy;

    always_comb begin
        if (!w_side_out.hit)    w_fdx = w_side_out.dx;
        else if (!w_side_out.en_x) w_fdx = '0;
        else                    w_fdx = w_side_out.neg_x ? 32'(-w_qx) : w_qx;
        if (!w_side_out.hit)    w_fdy = w_side_out.dy;
        else if (!w_side_out.en_y) w_fdy = '0;
        else                    w_fdy = w_side_out.neg_y ? 32'(-w_qy) : w_qy;
    end

    logic [IW-1:0]      r5_idx;
    logic signed [31:0] r5_x, r5_y;
    logic               r5_hit;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_idx <= w_side_out.idx;
            r5_x   <= pae_pkg::sat32(36'(w_side_out.px) + 36'(w_fdx));
            r5_y   <= pae_pkg::sat32(36'(w_side_out.py) + 36'(w_fdy));
            r5_hit <= w_side_out.hit;
        end
    end

    // ---------------- stage 6: wrap, clamp, output register ----------------
    logic               w_wrap;
    logic signed [31:0] w_x0, w_y0, w_x1, w_y1;

    always_comb begin
        w_wrap = (r5_x > r_xu);
        w_x0   = w_wrap ? r_xl : r5_x;
        w_y0   = w_wrap ? r_ry : r5_y;
        // lower bound first, then upper: crossed bounds give the upper one
        w_y1   = (w_y0 < r_yl) ? r_yl : w_y0;
        w_y1   = (w_y1 > r_yu) ? r_yu : w_y1;
        w_x1   = (w_x0 < r_xl) ? r_xl : w_x0;
        w_x1   = (w_x1 > r_xu) ? r_xu : w_x1;
    end

    logic [IW-1:0]      r6_idx;
    logic signed [31:0] r6_x, r6_y;
    logic               r6_hit, r6_wrap;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_idx  <= r5_idx;
            r6_x    <= w_x1;
            r6_y    <= w_y1;
            r6_hit  <= r5_hit;
            r6_wrap <= w_wrap;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v5 <= w_v4;
            r_v6 <= r_v5;
        end
    end

    assign o_m_axis_tvalid = r_v6;
    assign o_m_axis_tdata  = {r6_y, r6_x, 16'(r6_idx)};
    assign o_m_axis_tuser  = {r6_wrap, r6_hit};

endmodule
